>>> rtl/ipsm_pkg.sv
// Shared types and constants for the subnet match filter.
package ipsm_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

  localparam int ADDR_HALF_W = 64;
  localparam int PREFIX_W    = 8;
  localparam int COUNT_REG_W = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [PREFIX_W-1:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [PREFIX_W-1:0] V6_MAX_PREFIX = 8'd128;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // register index as taken from paddr[2]
  localparam logic REG_ACTIVE_COUNT = 1'b0;

  typedef struct packed {
    logic [ADDR_HALF_W-1:0] addr_hi;
    logic [ADDR_HALF_W-1:0] addr_lo;
    logic [PREFIX_W-1:0]    prefix;
    logic                   v6;
  } rule_t;

endpackage

>>> rtl/ip_subnet_match_filter.sv
// Subnet match filter top level: rule table, scan sequencer and APB register.
// A load word writes its rule slot and the block is ready again next cycle.
// A check word scans N = min(active count, slots) rules from the table, then registers the
// drop word; one rule is read and compared per cycle, and no new word is taken until the
// drop word has been registered. Invalid addresses and a zero count skip the scan. A drop word
// still waiting holds the block. Synchronous active-high reset clears control state and count.
module ip_subnet_match_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ipsm_pkg::PDATA_W-1:0]  pwdata,
  output logic [ipsm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [3:0]                    slot,
  input  logic [63:0]                   addr_high,
  input  logic [63:0]                   addr_low,
  input  logic                          is_ipv6,
  input  logic [7:0]                    prefix_len,
  input  logic                          address_valid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          drop
);
  import ipsm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  logic [COUNT_REG_W-1:0] active_rule_count;
  logic [CNT_W-1:0]       count_eff;
  logic [CNT_W-1:0]       scan_count;
  logic [CNT_W-1:0]       issue_cnt;
  logic                   rd_en;
  logic                   rd_pending;
  rule_t                  rd_rule;
  rule_t                  rule_mem [RULE_SLOTS];
  rule_t                  wr_rule;
  logic [PREFIX_W-1:0]    max_prefix;
  logic                   in_acc;
  logic                   cfg_wr;
  logic [63:0]            chk_hi;
  logic [63:0]            chk_lo;
  logic                   chk_v6;
  logic                   cmp_hit;
  logic                   res_hit;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACTIVE_COUNT) ?
                  PDATA_W'(active_rule_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rule_count <= '0;
    end else if (cfg_wr && paddr[2] == REG_ACTIVE_COUNT) begin
      active_rule_count <= pwdata[COUNT_REG_W-1:0];
    end
  end

  always_comb begin
    if (int'(active_rule_count) > RULE_SLOTS) begin
      count_eff = CNT_W'(RULE_SLOTS);
    end else begin
      count_eff = CNT_W'(active_rule_count);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // rule table
  assign max_prefix      = is_ipv6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
  assign wr_rule.addr_hi = addr_high;
  assign wr_rule.addr_lo = addr_low;
  assign wr_rule.prefix  = (prefix_len > max_prefix) ? max_prefix : prefix_len;
  assign wr_rule.v6      = is_ipv6;

  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_LOAD && int'(slot) < RULE_SLOTS) begin
      rule_mem[IDX_W'(slot)] <= wr_rule;
    end
  end

  assign rd_en = (state == ST_SCAN) && (issue_cnt < scan_count);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule <= rule_mem[IDX_W'(issue_cnt)];
    end
  end

  ipsm_rule_cmp u_cmp (
    .addr_hi (chk_hi),
    .addr_lo (chk_lo),
    .v6      (chk_v6),
    .rule    (rd_rule),
    .hit     (cmp_hit)
  );

  // check word latch and result accumulation
  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_CHECK) begin
      chk_hi     <= addr_high;
      chk_lo     <= addr_low;
      chk_v6     <= is_ipv6;
      scan_count <= count_eff;
      issue_cnt  <= '0;
      res_hit    <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      res_hit <= res_hit | (rd_pending & cmp_hit);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      case (state)
        ST_IDLE: begin
          if (in_acc && opcode == OP_CHECK) begin
            if (address_valid && count_eff != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // last compare lands in the cycle with no further read
          if (!rd_en) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      drop <= res_hit;
    end
  end

`ifndef ASSERT_OFF
  a_invalid_passes: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_CHECK && !address_valid) |=> (state == ST_DONE && !res_hit))
    else $error("invalid address did not resolve to pass");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= scan_count))
    else $error("rule scan ran past the active count");

  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_LOAD) |=> in_ready)
    else $error("load word left the block busy");
`endif

endmodule

>>> rtl/ipsm_rule_cmp.sv
// Prefix compare unit: tests one stored rule against the address under check.
module ipsm_rule_cmp (
  input  logic [63:0]   addr_hi,
  input  logic [63:0]   addr_lo,
  input  logic          v6,
  input  ipsm_pkg::rule_t rule,
  output logic          hit
);
  import ipsm_pkg::*;

  logic [2*ADDR_HALF_W-1:0] mask;
  logic [2*ADDR_HALF_W-1:0] diff;

  // bit b counted from the MSB is kept when b < prefix
  always_comb begin
    for (int b = 0; b < 2*ADDR_HALF_W; b++) begin
      mask[2*ADDR_HALF_W-1-b] = (b < int'(rule.prefix));
    end
  end

  assign diff = {addr_hi, addr_lo} ^ {rule.addr_hi, rule.addr_lo};
  assign hit  = (v6 == rule.v6) && ((diff & mask) == '0);

endmodule

>>> tb/sv/ipsm_checker.sv
// Checker for the subnet match filter: shadows rule table and count, predicts and compares drop words.
module ipsm_checker
  import ipsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               opcode,
  input  logic [3:0]         slot,
  input  logic [63:0]        addr_high,
  input  logic [63:0]        addr_low,
  input  logic               is_ipv6,
  input  logic [7:0]         prefix_len,
  input  logic               address_valid,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               drop,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  rule_t                  rule_tab [RULE_SLOTS];
  logic [COUNT_REG_W-1:0] active_count;
  logic                   expected_drop [$];
  logic                   want;
  logic [PREFIX_W-1:0]    cap;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // drop when the address is valid and any consulted rule of the same family agrees on its leading prefix bits
  function automatic logic predict_drop(input logic [127:0] a, input logic v6, input logic ok);
    int           n;
    logic         hit;
    logic [127:0] mask;
    n   = (int'(active_count) > RULE_SLOTS) ? RULE_SLOTS : int'(active_count);
    hit = 1'b0;
    if (ok) begin
      for (int i = 0; i < n; i++) begin
        // a prefix of zero shifts every bit out, so the mask is empty
        mask = {128{1'b1}} << (128 - int'(rule_tab[i].prefix));
        if (rule_tab[i].v6 == v6 &&
            ((a ^ {rule_tab[i].addr_hi, rule_tab[i].addr_lo}) & mask) == '0)
          hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      active_count = '0;
      expected_drop.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drop.size() == 0) begin
          report_mismatch($sformatf("drop word %b with nothing expected", drop));
        end else begin
          want = expected_drop.pop_front();
          if (drop !== want)
            report_mismatch($sformatf("drop %b, expected %b", drop, want));
        end
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_LOAD) begin
          if (int'(slot) < RULE_SLOTS) begin
            cap = is_ipv6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
            rule_tab[slot].addr_hi = addr_high;
            rule_tab[slot].addr_lo = addr_low;
            rule_tab[slot].prefix  = (prefix_len > cap) ? cap : prefix_len;
            rule_tab[slot].v6      = is_ipv6;
          end
        end else begin
          expected_drop.push_back(predict_drop({addr_high, addr_low}, is_ipv6, address_valid));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_COUNT)
        active_count = pwdata[COUNT_REG_W-1:0];
    end
    pending <= expected_drop.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the subnet match filter testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import ipsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REG_SPARE   = 1'b1;  // unused register index
  localparam int   IDLE_LIMIT  = 2000;
  localparam int   SETTLE_WAIT = 24;
  localparam int   PHASE_WORDS = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               opcode = OP_LOAD;
  logic [3:0]         slot = '0;
  logic [63:0]        addr_high = '0;
  logic [63:0]        addr_low = '0;
  logic               is_ipv6 = 1'b0;
  logic [7:0]         prefix_len = '0;
  logic               address_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               drop;

  logic               calm = 1'b0;
  int                 mismatches;
  int                 pending;
  int                 idle_cycles = 0;
  logic [4:0]         count_now = '0;

  // stimulus-side copy of the loaded rules, used to aim checks at them
  logic [127:0]       sh_addr [RULE_SLOTS];
  logic [7:0]         sh_len  [RULE_SLOTS];
  logic               sh_v6   [RULE_SLOTS];

  int                 phase_count [10] = '{16, 31, 1, 17, 0, 8, 3, 24, 16, 15};

  ip_subnet_match_filter uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slot(slot), .addr_high(addr_high), .addr_low(addr_low),
    .is_ipv6(is_ipv6), .prefix_len(prefix_len), .address_valid(address_valid),
    .out_valid(out_valid), .out_ready(out_ready), .drop(drop)
  );

  ipsm_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slot(slot), .addr_high(addr_high), .addr_low(addr_low),
    .is_ipv6(is_ipv6), .prefix_len(prefix_len), .address_valid(address_valid),
    .out_valid(out_valid), .out_ready(out_ready), .drop(drop),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 10);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // valid stays up across back-to-back words; it only drops for a gap
  task automatic send_word(input logic op, input logic [3:0] s, input logic [127:0] a,
                           input logic v6, input logic [7:0] plen, input logic ok);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    slot          <= s;
    addr_high     <= a[127:64];
    addr_low      <= a[63:0];
    is_ipv6       <= v6;
    prefix_len    <= plen;
    address_valid <= ok;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_rule(input logic [3:0] s, input logic [127:0] a, input logic v6,
                           input logic [7:0] plen);
    logic [7:0] cap;
    cap        = v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
    sh_addr[s] = a;
    sh_len[s]  = (plen > cap) ? cap : plen;
    sh_v6[s]   = v6;
    send_word(OP_LOAD, s, a, v6, plen, 1'($urandom_range(1)));
  endtask

  task automatic check_addr(input logic [127:0] a, input logic v6, input logic ok);
    send_word(OP_CHECK, 4'($urandom_range(15)), a, v6, 8'($urandom_range(255)), ok);
  endtask

  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drain, let any trailing load finish, optionally poke the spare register, then reprogram the count
  task automatic settle_and_set(input logic [4:0] c, input logic poke_spare);
    logic [31:0] junk;
    junk = $urandom;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (poke_spare)
      apb_write(REG_SPARE, $urandom);
    apb_write(REG_ACTIVE_COUNT, {junk[31:5], c});
    count_now = c;
  endtask

  task automatic random_load(input logic [3:0] s);
    logic [127:0] a;
    logic         v6;
    logic [7:0]   plen;
    int           pick;
    v6   = 1'($urandom_range(1));
    a    = rand128();
    if (!v6 && $urandom_range(3) != 0)
      a[63:0] = '0;
    pick = $urandom_range(99);
    if (pick < 10)
      plen = 8'd0;
    else if (pick < 20)
      plen = v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
    else if (pick < 80)
      plen = 8'($urandom_range(v6 ? 128 : 32, 1));
    else
      plen = 8'($urandom_range(255, v6 ? 129 : 33));
    load_rule(s, a, v6, plen);
  endtask

  task automatic random_check();
    int           n;
    int           r;
    int           p;
    logic [127:0] a;
    logic [127:0] keep;
    logic         v6;
    logic         ok;
    n  = (count_now > 5'd16) ? RULE_SLOTS : int'(count_now);
    ok = ($urandom_range(99) >= 10);
    a  = rand128();
    v6 = 1'($urandom_range(1));
    if (n > 0 && $urandom_range(99) < 80) begin
      // aim at a consulted rule: keep its prefix, randomise the rest
      r    = $urandom_range(n - 1);
      keep = {128{1'b1}} << (128 - int'(sh_len[r]));
      a    = (sh_addr[r] & keep) | (a & ~keep);
      v6   = ($urandom_range(9) == 0) ? ~sh_v6[r] : sh_v6[r];
      // sometimes break one prefix bit, often the last one
      if (sh_len[r] != 0 && $urandom_range(1) == 1) begin
        p = ($urandom_range(1) == 1) ? int'(sh_len[r]) - 1 : $urandom_range(int'(sh_len[r]) - 1);
        a[127 - p] = ~a[127 - p];
      end
    end
    check_addr(a, v6, ok);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // count is zero out of reset: everything passes
    check_addr({32'hFFFF_FFFF, 96'd0}, 1'b0, 1'b1);
    check_addr('0, 1'b1, 1'b0);

    load_rule(4'd0, {32'hC0A8_0100, 96'd0}, 1'b0, 8'd24);
    load_rule(4'd1, {32'h0A01_0203, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, 8'd200);
    load_rule(4'd2, {64'h2001_0DB8_0000_0000, 64'd0}, 1'b1, 8'd32);
    load_rule(4'd3, {128{1'b1}}, 1'b1, 8'd255);
    load_rule(4'd4, {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, 1'b1, 8'd0);

    settle_and_set(5'd4, 1'b0);
    check_addr({32'hC0A8_014D, 96'd0}, 1'b0, 1'b1);
    check_addr({32'hC0A8_024D, 96'd0}, 1'b0, 1'b1);
    check_addr({32'hC0A8_014D, 96'd0}, 1'b0, 1'b0);
    check_addr({32'hC0A8_014D, 96'd0}, 1'b1, 1'b1);
    check_addr({32'h0A01_0203, 96'd0}, 1'b0, 1'b1);
    check_addr({32'h0A01_0202, 96'd0}, 1'b0, 1'b1);
    check_addr({64'h2001_0DB8_FFFF_0000, 64'd1}, 1'b1, 1'b1);
    check_addr({64'h2001_0DB9_0000_0000, 64'd0}, 1'b1, 1'b1);
    check_addr({128{1'b1}}, 1'b1, 1'b1);
    check_addr({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b1, 1'b1);

    // slot 4 has prefix zero: any IPv6 word hits
    settle_and_set(5'd5, 1'b1);
    check_addr({64'h2001_0DB9_0000_0000, 64'd0}, 1'b1, 1'b1);
    check_addr({32'h0808_0808, 96'd0}, 1'b0, 1'b1);

    settle_and_set(5'd0, 1'b0);
    check_addr({32'hC0A8_014D, 96'd0}, 1'b0, 1'b1);

    // fill the whole table so any count is safe from here on
    for (int s = 0; s < RULE_SLOTS; s++)
      random_load(s[3:0]);

    for (int ph = 0; ph < 10; ph++) begin
      settle_and_set(phase_count[ph][4:0], ph == 2);
      calm <= (ph == 5);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(99) < 25)
          random_load(4'($urandom_range(15)));
        else
          random_check();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/ipsm_pkg.sv
rtl/ipsm_rule_cmp.sv
rtl/ip_subnet_match_filter.sv
tb/sv/ipsm_checker.sv
tb/sv/testbench.sv
